[rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Field widths, status and operation codes and register indexes shared by
// the allocator and its users.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

   localparam int FRAME_W     = 52;
   localparam int ORDER_W     = 4;
   localparam int COUNT_W     = 11;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 56;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ORDER = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_COUNT  = 1'b1;

endpackage

`default_nettype wire

[rtl/buddy_page_allocator_top.sv]
// ----------------------------------------------------------------------------
// Buddy page allocator
// Per-order FIFO free lists over a page region, kept in one node memory.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one allocate or free per transfer; the rsp channel
// returns exactly one result per request, in order. The csr port writes
// region_base (index 0) and page_count (index 1); the user must write them
// only while the block is idle, which the block leaves unchecked; writing
// page_count rebuilds the free lists.
// Every list operation is a read-modify-write of the single node memory
// (one read and one write port, registered read), so a request is worked
// through in steps: an allocate searches the lists upward from its order,
// unlinks the block found and puts back one upper half per split; a free
// checks the frame, merges with a free buddy step by step up to MAX_ORDER,
// makes a last buddy check and appends the block. The sequencer returns to
// idle before the next request is accepted. One request is worked on at a
// time; req_tready is high only when idle.
// After reset and after each page_count write the block clears every node
// of the memory and then rebuilds the lists before it accepts a request.
// A result waits in the output register while rsp_tready is low; the next
// request may still be taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator_top #(
   parameter int PAGES     = 1024,
   parameter int MAX_ORDER = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bpa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bpa_pkg::FRAME_W-1:0]         csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [3:0] request_order, [55:4] page_frame
   input  logic [bpa_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] operation
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [51:0] result_frame, [55:52] result_order
   output logic [bpa_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [bpa_pkg::STATUS_W-1:0]        rsp_tuser
);
   import bpa_pkg::*;

   localparam int PW  = $clog2(PAGES + 1);
   localparam int AW  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int LW  = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
   localparam int XW0 = (PW > MAX_ORDER + 1) ? PW : MAX_ORDER + 1;
   localparam int XW  = ((XW0 > COUNT_W) ? XW0 : COUNT_W) + 1;
   localparam int IW  = ORDER_W + 1;
   localparam int SW  = 5;
   localparam logic [PW-1:0] NIL     = PW'(PAGES);
   localparam logic [XW-1:0] PAGES_X = XW'(PAGES);

   localparam logic [SW-1:0] S_IDLE     = 5'd0;
   localparam logic [SW-1:0] S_CLR      = 5'd1;
   localparam logic [SW-1:0] S_RB_INIT  = 5'd2;
   localparam logic [SW-1:0] S_RB       = 5'd3;
   localparam logic [SW-1:0] S_AL_SRCH  = 5'd4;
   localparam logic [SW-1:0] S_AL_SPL   = 5'd5;
   localparam logic [SW-1:0] S_FR_SUB   = 5'd6;
   localparam logic [SW-1:0] S_FR_CHK   = 5'd7;
   localparam logic [SW-1:0] S_FR_FCHK  = 5'd8;
   localparam logic [SW-1:0] S_FR_MG    = 5'd9;
   localparam logic [SW-1:0] S_FR_BDCHK = 5'd10;
   localparam logic [SW-1:0] S_FR_APP   = 5'd11;
   localparam logic [SW-1:0] S_FR_DONE  = 5'd12;
   localparam logic [SW-1:0] S_RESP     = 5'd13;
   localparam logic [SW-1:0] U_RD       = 5'd14;
   localparam logic [SW-1:0] U_CHK      = 5'd15;
   localparam logic [SW-1:0] U_PWR      = 5'd16;
   localparam logic [SW-1:0] U_X        = 5'd17;
   localparam logic [SW-1:0] U_XWR      = 5'd18;
   localparam logic [SW-1:0] A_RD       = 5'd19;
   localparam logic [SW-1:0] A_CHK      = 5'd20;
   localparam logic [SW-1:0] A_TAIL     = 5'd21;
   localparam logic [SW-1:0] A_TWR      = 5'd22;

   typedef struct packed {
      logic               free;
      logic [ORDER_W-1:0] order;
      logic [PW-1:0]      prev;
      logic [PW-1:0]      next;
   } node_type;

   typedef struct packed {
      logic [SW-1:0]       u_ret;
      logic [SW-1:0]       a_ret;
      logic [PW-1:0]       clr;
      logic [XW-1:0]       rb_off;
      logic [XW-1:0]       rb_left;
      logic [ORDER_W-1:0]  rb_o;
      logic [ORDER_W-1:0]  ord;
      logic [FRAME_W-1:0]  frame;
      logic [FRAME_W-1:0]  off;
      logic [IW-1:0]       i;
      logic [ORDER_W-1:0]  r;
      logic [PW-1:0]       pg;
      logic [PW-1:0]       rem;
      logic [ORDER_W-1:0]  o;
      logic [PW-1:0]       u_node;
      logic [PW-1:0]       u_p;
      logic [PW-1:0]       u_x;
      logic [ORDER_W-1:0]  u_o;
      logic [PW-1:0]       a_node;
      logic [PW-1:0]       a_t;
      logic [ORDER_W-1:0]  a_ord;
      logic [STATUS_W-1:0] res_status;
      logic [FRAME_W-1:0]  res_frame;
      logic [ORDER_W-1:0]  res_order;
   } work_type;

   logic [SW-1:0]       state_ff, state_in;
   work_type            w_ff, w_in;
   logic [PW-1:0]       head_ff [MAX_ORDER+1];
   logic [PW-1:0]       head_in [MAX_ORDER+1];
   logic [PW-1:0]       tail_ff [MAX_ORDER+1];
   logic [PW-1:0]       tail_in [MAX_ORDER+1];
   logic [FRAME_W-1:0]  base_ff, base_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [ORDER_W-1:0]  rsp_order_ff, rsp_order_in;

   node_type            node_mem [PAGES];
   node_type            mem_q_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   node_type            mem_wdata;
   logic [AW-1:0]       rd_addr;

   logic [XW-1:0]       cnt_x;
   logic [XW-1:0]       rb_sz;
   logic [XW-1:0]       f_sz;
   logic [XW-1:0]       f_offx;
   logic [XW:0]         f_sum;
   logic                f_bad;
   logic [PW-1:0]       bd;
   logic [PW-1:0]       tail_t;
   logic [PW-1:0]       head_i;

   assign cnt_x  = (XW'(count_ff) > PAGES_X) ? PAGES_X : XW'(count_ff);
   assign rb_sz  = XW'(1) << w_ff.rb_o;
   assign f_sz   = XW'(1) << w_ff.ord;
   assign f_offx = w_ff.off[XW-1:0];
   assign f_sum  = {1'b0, f_offx} + {1'b0, f_sz};
   assign f_bad  = (|w_ff.off[FRAME_W-1:XW]) || (f_offx >= cnt_x)
                   || ((f_offx & (f_sz - 1'b1)) != '0) || (f_sum > {1'b0, cnt_x});
   assign bd     = w_ff.pg ^ (PW'(1) << w_ff.o);
   assign tail_t = tail_ff[w_ff.a_ord[LW-1:0]];
   assign head_i = head_ff[w_ff.i[LW-1:0]];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_order_ff, rsp_frame_ff};
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      w_in          = w_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_order_in  = rsp_order_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      rd_addr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               w_in.ord   = req_tdata[ORDER_W-1:0];
               w_in.frame = req_tdata[ORDER_W +: FRAME_W];
               w_in.i     = {1'b0, req_tdata[ORDER_W-1:0]};
               if (req_tdata[ORDER_W-1:0] > ORDER_W'(MAX_ORDER)) begin
                  w_in.res_status = STATUS_BAD_ORDER;
                  w_in.res_frame  = '0;
                  w_in.res_order  = '0;
                  state_in        = S_RESP;
               end else if (req_tuser[0] == OP_FREE) begin
                  state_in = S_FR_SUB;
               end else begin
                  state_in = S_AL_SRCH;
               end
            end
         end
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = w_ff.clr[AW-1:0];
            if (w_ff.clr == PW'(PAGES - 1)) begin
               state_in = S_RB_INIT;
            end else begin
               w_in.clr = w_ff.clr + 1'b1;
            end
         end
         S_RB_INIT: begin
            for (int k = 0; k <= MAX_ORDER; k++) begin
               head_in[k] = NIL;
               tail_in[k] = NIL;
            end
            w_in.rb_off  = '0;
            w_in.rb_left = cnt_x;
            w_in.rb_o    = ORDER_W'(MAX_ORDER);
            state_in     = S_RB;
         end
         S_RB: begin
            // Greedy carve: largest order that still fits, from the region start.
            if (w_ff.rb_left == '0) begin
               state_in = S_IDLE;
            end else if (w_ff.rb_left >= rb_sz) begin
               w_in.a_node  = w_ff.rb_off[PW-1:0];
               w_in.a_ord   = w_ff.rb_o;
               w_in.a_ret   = S_RB;
               w_in.rb_off  = w_ff.rb_off + rb_sz;
               w_in.rb_left = w_ff.rb_left - rb_sz;
               state_in     = A_RD;
            end else begin
               w_in.rb_o = w_ff.rb_o - 1'b1;
            end
         end
         S_AL_SRCH: begin
            if (w_ff.i > IW'(MAX_ORDER)) begin
               w_in.res_status = STATUS_NO_BLOCK;
               w_in.res_frame  = '0;
               w_in.res_order  = '0;
               state_in        = S_RESP;
            end else if (head_i >= NIL) begin
               w_in.i = w_ff.i + 1'b1;
            end else begin
               w_in.pg     = head_i;
               w_in.u_node = head_i;
               w_in.u_ret  = S_AL_SPL;
               w_in.rem    = head_i + (PW'(1) << w_ff.ord);
               w_in.r      = w_ff.ord;
               state_in    = U_RD;
            end
         end
         S_AL_SPL: begin
            // Upper halves go back on the lower lists in rising order.
            if ({1'b0, w_ff.r} < w_ff.i) begin
               w_in.a_node = w_ff.rem;
               w_in.a_ord  = w_ff.r;
               w_in.a_ret  = S_AL_SPL;
               w_in.rem    = w_ff.rem + (PW'(1) << w_ff.r);
               w_in.r      = w_ff.r + 1'b1;
               state_in    = A_RD;
            end else begin
               w_in.res_status = STATUS_OK;
               w_in.res_frame  = base_ff + FRAME_W'(w_ff.pg);
               w_in.res_order  = w_ff.ord;
               state_in        = S_RESP;
            end
         end
         S_FR_SUB: begin
            w_in.off = w_ff.frame - base_ff;
            state_in = S_FR_CHK;
         end
         S_FR_CHK: begin
            rd_addr = f_offx[AW-1:0];
            w_in.pg = f_offx[PW-1:0];
            w_in.o  = w_ff.ord;
            if (f_bad) begin
               w_in.res_status = STATUS_OK;
               w_in.res_frame  = w_ff.frame;
               w_in.res_order  = w_ff.ord;
               state_in        = S_RESP;
            end else begin
               state_in = S_FR_FCHK;
            end
         end
         S_FR_FCHK: begin
            if (mem_q_ff.free) begin
               w_in.res_status = STATUS_OK;
               w_in.res_frame  = w_ff.frame;
               w_in.res_order  = w_ff.ord;
               state_in        = S_RESP;
            end else begin
               state_in = S_FR_MG;
            end
         end
         S_FR_MG: begin
            rd_addr = bd[AW-1:0];
            if (w_ff.o < ORDER_W'(MAX_ORDER) && bd < NIL) begin
               state_in = S_FR_BDCHK;
            end else begin
               state_in = S_FR_APP;
            end
         end
         S_FR_BDCHK: begin
            if (mem_q_ff.free && mem_q_ff.order == w_ff.o) begin
               w_in.u_node = bd;
               w_in.u_ret  = S_FR_MG;
               w_in.pg     = w_ff.pg & ~(PW'(1) << w_ff.o);
               w_in.o      = w_ff.o + 1'b1;
               state_in    = U_RD;
            end else begin
               state_in = S_FR_APP;
            end
         end
         S_FR_APP: begin
            w_in.a_node = w_ff.pg;
            w_in.a_ord  = w_ff.o;
            w_in.a_ret  = S_FR_DONE;
            state_in    = A_RD;
         end
         S_FR_DONE: begin
            w_in.res_status = STATUS_OK;
            w_in.res_frame  = base_ff + FRAME_W'(w_ff.pg);
            w_in.res_order  = w_ff.o;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = w_ff.res_status;
               rsp_frame_in  = w_ff.res_frame;
               rsp_order_in  = w_ff.res_order;
               state_in      = S_IDLE;
            end
         end
         U_RD: begin
            rd_addr  = w_ff.u_node[AW-1:0];
            state_in = U_CHK;
         end
         U_CHK: begin
            // The predecessor is read straight away; it is never the node itself.
            rd_addr = mem_q_ff.prev[AW-1:0];
            if (!mem_q_ff.free) begin
               state_in = w_ff.u_ret;
            end else begin
               mem_we         = 1'b1;
               mem_waddr      = w_ff.u_node[AW-1:0];
               mem_wdata      = mem_q_ff;
               mem_wdata.free = 1'b0;
               w_in.u_p       = mem_q_ff.prev;
               w_in.u_x       = mem_q_ff.next;
               w_in.u_o       = mem_q_ff.order;
               if (mem_q_ff.prev < NIL) begin
                  state_in = U_PWR;
               end else begin
                  head_in[mem_q_ff.order[LW-1:0]] = mem_q_ff.next;
                  state_in = U_X;
               end
            end
         end
         U_PWR: begin
            mem_we         = 1'b1;
            mem_waddr      = w_ff.u_p[AW-1:0];
            mem_wdata      = mem_q_ff;
            mem_wdata.next = w_ff.u_x;
            state_in       = U_X;
         end
         U_X: begin
            rd_addr = w_ff.u_x[AW-1:0];
            if (w_ff.u_x < NIL) begin
               state_in = U_XWR;
            end else begin
               tail_in[w_ff.u_o[LW-1:0]] = w_ff.u_p;
               state_in = w_ff.u_ret;
            end
         end
         U_XWR: begin
            mem_we         = 1'b1;
            mem_waddr      = w_ff.u_x[AW-1:0];
            mem_wdata      = mem_q_ff;
            mem_wdata.prev = w_ff.u_p;
            state_in       = w_ff.u_ret;
         end
         A_RD: begin
            rd_addr  = w_ff.a_node[AW-1:0];
            state_in = A_CHK;
         end
         A_CHK: begin
            // A page that already heads a free block leaves its list first.
            if (mem_q_ff.free) begin
               w_in.u_node = w_ff.a_node;
               w_in.u_ret  = A_TAIL;
               state_in    = U_RD;
            end else begin
               state_in = A_TAIL;
            end
         end
         A_TAIL: begin
            rd_addr         = tail_t[AW-1:0];
            mem_we          = 1'b1;
            mem_waddr       = w_ff.a_node[AW-1:0];
            mem_wdata.free  = 1'b1;
            mem_wdata.order = w_ff.a_ord;
            mem_wdata.prev  = tail_t;
            mem_wdata.next  = NIL;
            tail_in[w_ff.a_ord[LW-1:0]] = w_ff.a_node;
            w_in.a_t = tail_t;
            if (tail_t < NIL) begin
               state_in = A_TWR;
            end else begin
               head_in[w_ff.a_ord[LW-1:0]] = w_ff.a_node;
               state_in = w_ff.a_ret;
            end
         end
         A_TWR: begin
            mem_we         = 1'b1;
            mem_waddr      = w_ff.a_t[AW-1:0];
            mem_wdata      = mem_q_ff;
            mem_wdata.next = w_ff.a_node;
            state_in       = w_ff.a_ret;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         if (csr_index == CSR_REGION_BASE) begin
            base_in = csr_wdata;
         end else begin
            count_in = csr_wdata[COUNT_W-1:0];
            w_in.clr = '0;
            state_in = S_CLR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         w_ff.clr     <= '0;
         base_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_order_ff  <= rsp_order_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= node_mem[rd_addr];
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_free_order_range: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_wdata.free) |-> (mem_wdata.order <= ORDER_W'(MAX_ORDER)))
      else $error("free block written with an order above the maximum");

   a_rebuild_on_count: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == CSR_PAGE_COUNT) |=> (state_ff == S_CLR))
      else $error("page count write did not start the clearing pass");

   a_result_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_order_ff <= ORDER_W'(MAX_ORDER))
         && (rsp_status_ff == STATUS_OK || rsp_status_ff == STATUS_NO_BLOCK
             || rsp_status_ff == STATUS_BAD_ORDER)))
      else $error("result holds an impossible status or order");

endmodule

`default_nettype wire
